FILE: rtl/ple_pkg.sv
// ----------------------------------------------------------------------------
// ple_pkg: shared types and constants of the positional list engine
// Opcodes, status codes, storage sizes and the command and status bundles
// that run between the controller and the datapath.
// ----------------------------------------------------------------------------
package ple_pkg;

    localparam int CAPACITY = 64;
    localparam int ADDR_W   = 6;
    localparam int CNT_W    = 7;
    localparam int DATA_W   = 32;
    localparam int OP_W     = 3;
    localparam int ST_W     = 2;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT      = 3'd0,
        OP_APPEND      = 3'd1,
        OP_REMOVE_AT   = 3'd2,
        OP_REMOVE_LAST = 3'd3,
        OP_READ_AT     = 3'd4,
        OP_SEARCH      = 3'd5,
        OP_CLEAR       = 3'd6
    } op_t;

    typedef enum logic [ST_W-1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_BADPOS = 2'd2
    } status_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    capture;
        logic    idx_from_count;
        logic    idx_from_pos;
        logic    idx_zero;
        logic    idx_step_up;
        logic    idx_step_dn;
        logic    rd_idx;
        logic    rd_pos;
        logic    move_up;
        logic    move_dn;
        logic    cmp;
        logic    wr_val_pos;
        logic    wr_val_cnt;
        logic    cnt_inc;
        logic    cnt_dec;
        logic    cnt_clr;
        logic    set_placed;
        logic    take_read;
        logic    set_status;
        status_t status;
        logic    out_load;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            full;
        logic            pos_gt_cnt;
        logic            pos_ge_cnt;
        logic            pos_eq_cnt;
        logic            pos_is_last;
        logic            cnt_zero;
        logic            idx_at_pos;
        logic            idx_at_last;
        logic            out_free;
    } sts_t;

endpackage

FILE: rtl/ple_ctrl.sv
// ----------------------------------------------------------------------------
// ple_ctrl: operation sequencer of the positional list engine
// Decodes one operation, steps the datapath through shifts and searches, and
// hands the finished result to the output register.
// ----------------------------------------------------------------------------
module ple_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  ple_pkg::sts_t  sts,
    output ple_pkg::cmd_t  cmd
);
    import ple_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_SHUP,
        S_SHUP_TAIL,
        S_INS_WR,
        S_SHDN,
        S_SHDN_TAIL,
        S_SRCH,
        S_SRCH_TAIL,
        S_RD_WAIT,
        S_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE:
            begin
                state_next = S_FINISH;
                unique case (op_t'(sts.op))
                    OP_INSERT:
                    begin
                        priority if (sts.full)
                        begin
                            cmd.set_status = 1'b1;
                            cmd.status     = ST_FULL;
                        end
                        else if (sts.pos_gt_cnt)
                        begin
                            cmd.set_status = 1'b1;
                            cmd.status     = ST_BADPOS;
                        end
                        else if (sts.pos_eq_cnt)
                        begin
                            cmd.wr_val_pos = 1'b1;
                            cmd.cnt_inc    = 1'b1;
                        end
                        else
                        begin
                            cmd.idx_from_count = 1'b1;
                            state_next         = S_SHUP;
                        end
                    end
                    OP_APPEND:
                    begin
                        if (sts.full)
                        begin
                            cmd.set_status = 1'b1;
                            cmd.status     = ST_FULL;
                        end
                        else
                        begin
                            cmd.wr_val_cnt = 1'b1;
                            cmd.set_placed = 1'b1;
                            cmd.cnt_inc    = 1'b1;
                        end
                    end
                    OP_REMOVE_AT:
                    begin
                        priority if (sts.pos_ge_cnt)
                        begin
                            cmd.set_status = 1'b1;
                            cmd.status     = ST_BADPOS;
                        end
                        else if (sts.pos_is_last)
                        begin
                            cmd.cnt_dec = 1'b1;
                        end
                        else
                        begin
                            cmd.idx_from_pos = 1'b1;
                            state_next       = S_SHDN;
                        end
                    end
                    OP_REMOVE_LAST:
                    begin
                        if (sts.cnt_zero)
                        begin
                            cmd.set_status = 1'b1;
                            cmd.status     = ST_BADPOS;
                        end
                        else
                        begin
                            cmd.cnt_dec = 1'b1;
                        end
                    end
                    OP_READ_AT:
                    begin
                        if (sts.pos_ge_cnt)
                        begin
                            cmd.set_status = 1'b1;
                            cmd.status     = ST_BADPOS;
                        end
                        else
                        begin
                            cmd.rd_pos = 1'b1;
                            state_next = S_RD_WAIT;
                        end
                    end
                    OP_SEARCH:
                    begin
                        if (!sts.cnt_zero)
                        begin
                            cmd.idx_zero = 1'b1;
                            state_next   = S_SRCH;
                        end
                    end
                    OP_CLEAR:
                    begin
                        cmd.cnt_clr = 1'b1;
                    end
                    default:
                    begin
                        state_next = S_FINISH;
                    end
                endcase
            end
            S_SHUP:
            begin
                cmd.rd_idx  = 1'b1;
                cmd.move_up = 1'b1;
                if (sts.idx_at_pos)
                begin
                    state_next = S_SHUP_TAIL;
                end
                else
                begin
                    cmd.idx_step_dn = 1'b1;
                end
            end
            S_SHUP_TAIL:
            begin
                // The last moved word is written back in this cycle.
                state_next = S_INS_WR;
            end
            S_INS_WR:
            begin
                cmd.wr_val_pos = 1'b1;
                cmd.cnt_inc    = 1'b1;
                state_next     = S_FINISH;
            end
            S_SHDN:
            begin
                cmd.rd_idx  = 1'b1;
                cmd.move_dn = 1'b1;
                if (sts.idx_at_last)
                begin
                    state_next = S_SHDN_TAIL;
                end
                else
                begin
                    cmd.idx_step_up = 1'b1;
                end
            end
            S_SHDN_TAIL:
            begin
                cmd.cnt_dec = 1'b1;
                state_next  = S_FINISH;
            end
            S_SRCH:
            begin
                cmd.rd_idx = 1'b1;
                cmd.cmp    = 1'b1;
                if (sts.idx_at_last)
                begin
                    state_next = S_SRCH_TAIL;
                end
                else
                begin
                    cmd.idx_step_up = 1'b1;
                end
            end
            S_SRCH_TAIL:
            begin
                state_next = S_FINISH;
            end
            S_RD_WAIT:
            begin
                cmd.take_read = 1'b1;
                state_next    = S_FINISH;
            end
            S_FINISH:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: rtl/ple_dp.sv
// ----------------------------------------------------------------------------
// ple_dp: datapath of the positional list engine
// Holds the list memory, the entry count, the walk index, the result fields
// and the output register.
// ----------------------------------------------------------------------------
module ple_dp (
    input  logic                         clk,
    input  logic                         rst_n,
    input  ple_pkg::cmd_t                cmd,
    output ple_pkg::sts_t                sts,
    input  logic [ple_pkg::OP_W-1:0]     opcode,
    input  logic [ple_pkg::CNT_W-1:0]    position,
    input  logic signed [ple_pkg::DATA_W-1:0] value,
    input  logic                         cfg_valid,
    input  logic [ple_pkg::CNT_W-1:0]    cfg_data,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [ple_pkg::ST_W-1:0]     status,
    output logic signed [ple_pkg::DATA_W-1:0] read_value,
    output logic                         found,
    output logic [ple_pkg::ADDR_W-1:0]   placed_index,
    output logic [ple_pkg::CNT_W-1:0]    entry_count
);
    import ple_pkg::*;

    logic [OP_W-1:0]          op_reg;
    logic [CNT_W-1:0]         pos_reg;
    logic signed [DATA_W-1:0] val_reg;
    logic [CNT_W-1:0]         max_reg;
    logic [CNT_W-1:0]         count_reg;
    logic [ADDR_W-1:0]        idx_reg;
    logic signed [DATA_W-1:0] mem [CAPACITY];
    logic signed [DATA_W-1:0] rd_data_reg;
    logic                     move_pend_reg;
    logic [ADDR_W-1:0]        move_dest_reg;
    logic                     cmp_pend_reg;
    status_t                  status_reg;
    logic signed [DATA_W-1:0] rdv_reg;
    logic                     found_reg;
    logic [ADDR_W-1:0]        placed_reg;
    logic                     out_valid_reg;
    logic [ST_W-1:0]          out_status_reg;
    logic signed [DATA_W-1:0] out_rdv_reg;
    logic                     out_found_reg;
    logic [ADDR_W-1:0]        out_placed_reg;
    logic [CNT_W-1:0]         out_count_reg;
    logic [CNT_W-1:0]         limit;
    logic                     rd_en;
    logic [ADDR_W-1:0]        rd_addr;

    // A limit of zero, or any value above the built size, means the built size.
    assign limit = ((max_reg == '0) || (max_reg > CNT_W'(CAPACITY))) ?
                   CNT_W'(CAPACITY) : max_reg;

    assign sts.op          = op_reg;
    assign sts.full        = (count_reg >= limit);
    assign sts.pos_gt_cnt  = (pos_reg > count_reg);
    assign sts.pos_ge_cnt  = (pos_reg >= count_reg);
    assign sts.pos_eq_cnt  = (pos_reg == count_reg);
    assign sts.pos_is_last = (({1'b0, pos_reg} + 8'd1) == {1'b0, count_reg});
    assign sts.cnt_zero    = (count_reg == '0);
    assign sts.idx_at_pos  = ({1'b0, idx_reg} == pos_reg);
    assign sts.idx_at_last = (({1'b0, idx_reg} + CNT_W'(1)) == count_reg);
    assign sts.out_free    = !out_valid_reg || out_ready;

    assign rd_en   = cmd.rd_idx || cmd.rd_pos;
    assign rd_addr = cmd.rd_pos ? pos_reg[ADDR_W-1:0] : idx_reg;

    // List memory: one write port, one read port with registered data.
    always_ff @(posedge clk)
    begin
        priority if (move_pend_reg)
        begin
            mem[move_dest_reg] <= rd_data_reg;
        end
        else if (cmd.wr_val_pos)
        begin
            mem[pos_reg[ADDR_W-1:0]] <= val_reg;
        end
        else if (cmd.wr_val_cnt)
        begin
            mem[count_reg[ADDR_W-1:0]] <= val_reg;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Operand capture, walk index and result fields.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg  <= opcode;
            pos_reg <= position;
            val_reg <= value;
        end
        priority if (cmd.idx_from_count)
        begin
            idx_reg <= ADDR_W'(count_reg - CNT_W'(1));
        end
        else if (cmd.idx_from_pos)
        begin
            idx_reg <= ADDR_W'(pos_reg + CNT_W'(1));
        end
        else if (cmd.idx_zero)
        begin
            idx_reg <= '0;
        end
        else if (cmd.idx_step_up)
        begin
            idx_reg <= idx_reg + ADDR_W'(1);
        end
        else if (cmd.idx_step_dn)
        begin
            idx_reg <= idx_reg - ADDR_W'(1);
        end
        if (cmd.move_up || cmd.move_dn)
        begin
            move_dest_reg <= cmd.move_up ? (idx_reg + ADDR_W'(1)) :
                                           (idx_reg - ADDR_W'(1));
        end
        if (cmd.capture)
        begin
            status_reg <= ST_OK;
            rdv_reg    <= '0;
            found_reg  <= 1'b0;
            placed_reg <= '0;
        end
        else
        begin
            if (cmd.set_status)
            begin
                status_reg <= cmd.status;
            end
            if (cmd.take_read)
            begin
                rdv_reg <= rd_data_reg;
            end
            if (cmp_pend_reg && (rd_data_reg == val_reg))
            begin
                found_reg <= 1'b1;
            end
            if (cmd.set_placed)
            begin
                placed_reg <= count_reg[ADDR_W-1:0];
            end
        end
        if (cmd.out_load)
        begin
            out_status_reg <= status_reg;
            out_rdv_reg    <= rdv_reg;
            out_found_reg  <= found_reg;
            out_placed_reg <= placed_reg;
            out_count_reg  <= count_reg;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_reg       <= '0;
            count_reg     <= '0;
            move_pend_reg <= 1'b0;
            cmp_pend_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                max_reg <= cfg_data;
            end
            priority if (cmd.cnt_clr)
            begin
                count_reg <= '0;
            end
            else if (cmd.cnt_inc)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (cmd.cnt_dec)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
            move_pend_reg <= cmd.move_up || cmd.move_dn;
            cmp_pend_reg  <= cmd.cmp;
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = out_status_reg;
    assign read_value   = out_rdv_reg;
    assign found        = out_found_reg;
    assign placed_index = out_placed_reg;
    assign entry_count  = out_count_reg;

    // The count never passes the built size, and only grows below the limit.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_inc_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.cnt_inc |-> (count_reg < limit))
        else $error("entry count grows past the limit");

    // A new result never overwrites one that has not been taken.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || out_ready))
        else $error("result register overwritten");

    // A pending move owns the single write port.
    a_write_port: assert property (@(posedge clk) disable iff (!rst_n)
        move_pend_reg |-> !(cmd.wr_val_pos || cmd.wr_val_cnt))
        else $error("two writes to the list memory in one cycle");

endmodule

FILE: rtl/positional_list_engine_top.sv
// ----------------------------------------------------------------------------
// positional_list_engine_top: ordered list of signed 32-bit values
// Insert, append, remove, read, search and clear on a list held in memory.
// ----------------------------------------------------------------------------
// Usage. Each beat on the s_axis channel carries one operation; each
// operation returns exactly one result beat on the m_axis channel, in order.
// The cfg channel writes the capacity limit (0 selects the full 64 entries);
// it is always ready and should be written only while the engine is idle.
//
// Timing. One operation is handled at a time. An operation without a walk
// (append, remove last, clear, a refusal, insert at the end, removal of the
// last entry, search of an empty list) goes from decode straight to finish,
// and read first waits for the registered memory word; the result beat goes
// valid at the edge where s_axis_tready rises again. Insert at p below the
// count shifts the words from p up by one, remove at p below count - 1 shifts
// the words above p down by one, and a search compares each entry: walks move
// or compare one word per cycle through the single memory read and write ports.
//
// Reset clears the entry count, the limit and the output valid flag; the list
// memory is not cleared, since only entries below the count are ever read.
// A finished result sits in the output register while s_axis may already
// accept the next beat; that next operation then waits in its final cycle
// until m_axis takes the previous result, so a stalled receiver holds off
// further input only after one more operation has been taken in.
// ----------------------------------------------------------------------------
module positional_list_engine_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // opcode [2:0], position [9:3], value [41:10], zero [47:42]
    input  logic [47:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // status [1:0], read_value [33:2], found [34], placed_index [40:35],
    // entry_count [47:41]
    output logic [47:0] m_axis_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [6:0]  cfg_data
);
    import ple_pkg::*;

    cmd_t                     cmd;
    sts_t                     sts;
    logic [ST_W-1:0]          res_status;
    logic signed [DATA_W-1:0] res_read_value;
    logic                     res_found;
    logic [ADDR_W-1:0]        res_placed_index;
    logic [CNT_W-1:0]         res_entry_count;

    // The limit register can be written in any cycle.
    assign cfg_ready = 1'b1;

    ple_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ple_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .opcode       (s_axis_tdata[2:0]),
        .position     (s_axis_tdata[9:3]),
        .value        (s_axis_tdata[41:10]),
        .cfg_valid    (cfg_valid),
        .cfg_data     (cfg_data),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .status       (res_status),
        .read_value   (res_read_value),
        .found        (res_found),
        .placed_index (res_placed_index),
        .entry_count  (res_entry_count)
    );

    assign m_axis_tdata = {res_entry_count, res_placed_index, res_found,
                           res_read_value, res_status};

endmodule

FILE: dv/positional_list_engine_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// positional_list_engine_top_test: self-checking bench for the list engine
// Operation beats go in on s_axis and every result beat coming back on m_axis
// is compared field by field against an in-bench copy of the list. A short
// directed part covers the empty list, the extreme data words, the full and
// bad position refusals and a limit lowered below the count. After that,
// random traffic runs under several capacity limits. Both sides insert idle
// bursts, and one phase holds the receiver off long enough to back up input.
// ----------------------------------------------------------------------------
module positional_list_engine_top_test;

    import ple_pkg::*;

    // Opcode 7 is not in the package enum; the engine must treat it as a no-op.
    localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;

    // Longest stretch with no beat on any channel before the run is declared hung.
    // It is several times both the longest walk and the long receiver hold.
    localparam int STALL_LIMIT      = 2000;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int PRINT_CAP        = 40;

    // One decoded result beat.
    typedef struct {
        status_t         status;
        logic [31:0]     read_value;
        logic            found;
        logic [5:0]      placed_index;
        logic [CNT_W-1:0] entry_count;
    } list_result_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    // opcode [2:0], position [9:3], value [41:10], zero [47:42]
    logic [47:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    // status [1:0], read_value [33:2], found [34], placed_index [40:35],
    // entry_count [47:41]
    logic [47:0] m_axis_tdata;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [6:0]  cfg_data;

    // Bench copy of the engine state: the list words, the length and the
    // capacity limit register.
    logic [31:0]      list_copy [CAPACITY];
    int               list_length;
    logic [6:0]       limit_copy;

    // Results owed by the engine, oldest first.
    list_result_t     expected_list_results [$];

    // Knobs of the stimulus; the gap and hold knobs are shared with the result sink.
    bit gaps_enabled;
    bit hold_request;
    bit growing;

    // Run statistics.
    int error_count;
    int ops_sent;
    int results_checked;
    int peak_length;
    int full_refusals;
    int badpos_results;
    int search_hits;
    int limit_settings;
    int quiet_cycles;

    positional_list_engine_top DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------------
    // List behavior
    // ------------------------------------------------------------------------

    // A limit of zero, or any value above the built size, means the whole store.
    function automatic int effective_limit();
        if (limit_copy == 0 || limit_copy > CAPACITY)
            return CAPACITY;
        return limit_copy;
    endfunction

    // Applies one operation to the bench copy and returns the result the
    // engine must produce for it. Insert and append check for a full list first,
    // and insert looks at the position only then, so a full list wins over a bad one.
    task automatic compute_list_result(input logic [2:0] op, input logic [6:0] pos,
                                       input logic [31:0] val, output list_result_t r);
        int n;
        n = list_length;
        r.status       = ST_OK;
        r.read_value   = '0;
        r.found        = 1'b0;
        r.placed_index = '0;
        case (op)
            OP_INSERT:
            begin
                if (n >= effective_limit())
                    r.status = ST_FULL;
                else if (pos > n)
                    r.status = ST_BADPOS;
                else
                begin
                    for (int i = n; i > pos; i--)
                        list_copy[i] = list_copy[i - 1];
                    list_copy[pos] = val;
                    list_length = n + 1;
                end
            end
            OP_APPEND:
            begin
                if (n >= effective_limit())
                    r.status = ST_FULL;
                else
                begin
                    list_copy[n]   = val;
                    r.placed_index = n[5:0];
                    list_length    = n + 1;
                end
            end
            OP_REMOVE_AT:
            begin
                // An out-of-range remove leaves the list alone.
                if (pos >= n)
                    r.status = ST_BADPOS;
                else
                begin
                    for (int i = pos; i + 1 < n; i++)
                        list_copy[i] = list_copy[i + 1];
                    list_length = n - 1;
                end
            end
            OP_REMOVE_LAST:
            begin
                if (n == 0)
                    r.status = ST_BADPOS;
                else
                    list_length = n - 1;
            end
            OP_READ_AT:
            begin
                if (pos >= n)
                    r.status = ST_BADPOS;
                else
                    r.read_value = list_copy[pos];
            end
            OP_SEARCH:
            begin
                // Search always reports ok; only the flag carries the outcome.
                for (int i = 0; i < n; i++)
                begin
                    if (list_copy[i] == val)
                    begin
                        r.found = 1'b1;
                        break;
                    end
                end
            end
            OP_CLEAR:
                list_length = 0;
            default:
                ;
        endcase
        r.entry_count = list_length[CNT_W-1:0];

        if (r.status == ST_FULL)
            full_refusals++;
        if (r.status == ST_BADPOS)
            badpos_results++;
        if (r.found)
            search_hits++;
        if (list_length > peak_length)
            peak_length = list_length;
    endtask

    // ------------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------------

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        error_count++;
        if (error_count <= PRINT_CAP)
            $display("[%0t] result beat %0d: %s is %0h, expected %0h",
                     $realtime, results_checked, what, got, want);
    endtask

    task automatic check_result_beat(input logic [47:0] beat);
        list_result_t want;
        if (expected_list_results.size() == 0)
        begin
            report_mismatch("unexpected beat, data", beat[31:0], 32'h0);
            return;
        end
        want = expected_list_results.pop_front();
        if (beat[1:0] !== want.status)
            report_mismatch("status", beat[1:0], want.status);
        if (beat[33:2] !== want.read_value)
            report_mismatch("read_value", beat[33:2], want.read_value);
        if (beat[34] !== want.found)
            report_mismatch("found", beat[34], want.found);
        if (beat[40:35] !== want.placed_index)
            report_mismatch("placed_index", beat[40:35], want.placed_index);
        if (beat[47:41] !== want.entry_count)
            report_mismatch("entry_count", beat[47:41], want.entry_count);
        results_checked++;
    endtask

    // Result sink. It samples at the rising edge, before any of this edge's
    // updates land, so a beat counts when valid and ready were both high.
    // The ready line idles in random bursts while gaps are on; a hold request
    // from the stimulus turns into one long stall counted here.
    initial
    begin : result_sink
        int stall_left;
        stall_left = 0;
        m_axis_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
                check_result_beat(m_axis_tdata);
            if (hold_request)
            begin
                hold_request = 1'b0;
                stall_left   = LONG_HOLD_CYCLES;
            end
            else if (stall_left == 0 && gaps_enabled && $urandom_range(0, 4) == 0)
                stall_left = $urandom_range(1, 9);
            if (stall_left > 0)
            begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // Watchdog: any beat on any channel resets the count.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Watchdog: no beat moved for %0d cycles, %0d results outstanding",
                     quiet_cycles, expected_list_results.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Offers one operation beat and waits for it to be taken. Every call
    // starts on a rising edge, so valid is written once per time step: it is
    // either held high into the next beat or dropped for a random gap first.
    task automatic send_op(input logic [2:0] op, input logic [6:0] pos,
                           input logic [31:0] val);
        list_result_t r;
        if (gaps_enabled && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'b0, val, pos, op};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        compute_list_result(op, pos, val, r);
        expected_list_results.push_back(r);
        ops_sent++;
    endtask

    // Stops offering beats and waits for every owed result. Each operation
    // yields exactly one result, so once the queue is empty the engine has
    // nothing in flight; the settle cycles that follow let it return to ready.
    task automatic wait_until_idle(input int settle_cycles);
        s_axis_tvalid <= 1'b0;
        while (expected_list_results.size() != 0)
            @(posedge clk);
        repeat (settle_cycles) @(posedge clk);
    endtask

    task automatic set_capacity_limit(input logic [6:0] limit);
        cfg_valid <= 1'b1;
        cfg_data  <= limit;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid  <= 1'b0;
        limit_copy = limit;
        limit_settings++;
    endtask

    // Draws one operation. The traffic alternates between growing the list
    // toward the limit and draining it, so both the full list and the empty
    // list are reached often; about one item in ten gets a position drawn
    // from zero up to CAPACITY to hit the bad position paths.
    task automatic pick_random_op(output logic [2:0] op, output logic [6:0] pos,
                                  output logic [31:0] val);
        int n;
        int roll;
        n = list_length;
        if (n >= effective_limit())
            growing = 1'b0;
        else if (n == 0)
            growing = 1'b1;
        else if ($urandom_range(0, 49) == 0)
            growing = !growing;

        roll = $urandom_range(0, 99);
        if (growing)
            op = roll < 32 ? OP_INSERT :
                 roll < 64 ? OP_APPEND :
                 roll < 70 ? OP_REMOVE_AT :
                 roll < 74 ? OP_REMOVE_LAST :
                 roll < 86 ? OP_READ_AT : OP_SEARCH;
        else
            op = roll < 25 ? OP_REMOVE_AT :
                 roll < 50 ? OP_REMOVE_LAST :
                 roll < 58 ? OP_INSERT :
                 roll < 64 ? OP_APPEND :
                 roll < 80 ? OP_READ_AT :
                 roll < 97 ? OP_SEARCH : OP_CLEAR;

        if ($urandom_range(0, 9) == 0)
            pos = 7'($urandom_range(0, CAPACITY));
        else if (op == OP_INSERT)
            pos = 7'($urandom_range(0, n));
        else if (n > 0)
            pos = 7'($urandom_range(0, n - 1));
        else
            pos = '0;

        // Half the searches on a non-empty list look for a word that is in the list;
        // data words lean toward the extremes and a few small values that repeat.
        roll = $urandom_range(0, 9);
        if (op == OP_SEARCH && n > 0 && roll < 5)
            val = list_copy[$urandom_range(0, n - 1)];
        else if (roll == 5)
            val = 32'h8000_0000;
        else if (roll == 6)
            val = 32'h7fff_ffff;
        else if (roll == 7)
            val = $urandom_range(0, 3);
        else
            val = $urandom;
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Every operation that needs entries, on an empty list, plus the unused
    // opcode and a clear with nothing to clear.
    task automatic test_empty_list();
        send_op(OP_READ_AT,     7'd0, 32'h0);
        send_op(OP_REMOVE_AT,   7'd0, 32'h0);
        send_op(OP_REMOVE_LAST, 7'd0, 32'h0);
        send_op(OP_SEARCH,      7'd0, 32'h0);
        send_op(OP_UNUSED,      7'd64, 32'hffff_ffff);
        send_op(OP_CLEAR,       7'd0, 32'h0);
    endtask

    // Extreme data words, inserts at the head and the tail, positions one
    // past the end and at the built size, and removes in the middle and at the tail.
    task automatic test_edge_values();
        send_op(OP_APPEND,    7'd0,  32'h7fff_ffff);
        send_op(OP_APPEND,    7'd0,  32'h8000_0000);
        send_op(OP_INSERT,    7'd0,  32'hffff_ffff);
        send_op(OP_INSERT,    7'd3,  32'h0000_0000);
        send_op(OP_INSERT,    7'd5,  32'h5555_5555);
        send_op(OP_INSERT,    7'd64, 32'haaaa_aaaa);
        send_op(OP_READ_AT,   7'd0,  32'h0);
        send_op(OP_READ_AT,   7'd3,  32'h0);
        send_op(OP_READ_AT,   7'd4,  32'h0);
        send_op(OP_READ_AT,   7'd64, 32'h0);
        send_op(OP_SEARCH,    7'd0,  32'h8000_0000);
        send_op(OP_SEARCH,    7'd0,  32'h0001_2345);
        send_op(OP_REMOVE_AT, 7'd1,  32'h0);
        send_op(OP_REMOVE_AT, 7'd2,  32'h0);
        send_op(OP_REMOVE_AT, 7'd2,  32'h0);
        send_op(OP_REMOVE_AT, 7'd64, 32'h0);
    endtask

    // Lowers the limit under the current length: inserts and appends are
    // refused as full, even with a bad position, until the list shrinks below
    // the new limit.
    task automatic test_limit_below_count();
        wait_until_idle(4);
        set_capacity_limit(7'd1);
        send_op(OP_INSERT,      7'd0,  32'h1234_5678);
        send_op(OP_APPEND,      7'd0,  32'h1234_5678);
        send_op(OP_INSERT,      7'd64, 32'h1234_5678);
        send_op(OP_REMOVE_LAST, 7'd0,  32'h0);
        send_op(OP_APPEND,      7'd0,  32'h0f0f_0f0f);
        send_op(OP_CLEAR,       7'd0,  32'h0);
        send_op(OP_APPEND,      7'd0,  32'hf0f0_f0f0);
        send_op(OP_APPEND,      7'd0,  32'h0f0f_0f0f);
    endtask

    // One phase of random traffic under a given limit. The limit is written
    // only once the engine has drained.
    task automatic test_random_traffic(input logic [6:0] limit, input int n_items,
                                       input bit gaps, input bit long_hold);
        logic [2:0]  op;
        logic [6:0]  pos;
        logic [31:0] val;
        wait_until_idle(4);
        set_capacity_limit(limit);
        gaps_enabled = gaps;
        growing      = 1'b1;
        if (long_hold)
            hold_request = 1'b1;
        repeat (n_items)
        begin
            pick_random_op(op, pos, val);
            send_op(op, pos, val);
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        cfg_valid     <= 1'b0;
        cfg_data      <= '0;
        list_length     = 0;
        limit_copy      = '0;
        gaps_enabled    = 1'b1;
        hold_request    = 1'b0;
        growing         = 1'b1;
        error_count     = 0;
        ops_sent        = 0;
        results_checked = 0;
        peak_length     = 0;
        full_refusals   = 0;
        badpos_results  = 0;
        search_hits     = 0;
        limit_settings  = 0;
        quiet_cycles    = 0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // The directed part starts with the reset limit, which selects the full store.
        test_empty_list();
        test_edge_values();
        test_limit_below_count();

        // Random part: the full store written both as 64 and as 0, the
        // smallest limits, one just under the top and one in the middle.
        // The phase under limit 63 carries the long receiver hold; the last
        // phase runs with no idling on either side.
        test_random_traffic(7'd64, 150, 1'b1, 1'b0);
        test_random_traffic(7'd2,   40, 1'b1, 1'b0);
        test_random_traffic(7'd63, 150, 1'b1, 1'b1);
        test_random_traffic(7'd17, 100, 1'b1, 1'b0);
        test_random_traffic(7'd1,   30, 1'b1, 1'b0);
        test_random_traffic(7'd0,  130, 1'b0, 1'b0);

        // Drain, then give the engine a worst-case walk's time to show any
        // stray result beat.
        wait_until_idle(80);
        if (expected_list_results.size() != 0)
            report_mismatch("results never returned", expected_list_results.size(), 0);

        $display("Ran %0d operations under %0d limit settings; %0d results checked,",
                 ops_sent, limit_settings, results_checked);
        $display("longest list %0d; seen %0d full refusals, %0d bad position results, %0d hits.",
                 peak_length, full_refusals, badpos_results, search_hits);
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/ple_pkg.sv
rtl/ple_ctrl.sv
rtl/ple_dp.sv
rtl/positional_list_engine_top.sv
dv/positional_list_engine_top_test.sv
